### design/avd_pkg.sv
package avd_pkg;

  // Item kind, carried on the input tuser bit
  typedef enum logic {
    CMD_DECODE = 1'b0,
    CMD_START  = 1'b1
  } command_t;

  // Per-voice decoder state as held in the state memory
  typedef struct packed {
    logic signed [11:0] signal;
    logic [5:0]         step;
    logic               mode;
  } voice_state_t;

  localparam logic signed [11:0] SIGNAL_RESET = -12'sd2;
  localparam logic signed [13:0] SIGNAL_MAX   = 14'sd2047;
  localparam logic signed [13:0] SIGNAL_MIN   = -14'sd2048;
  localparam logic [5:0]         STEP_MAX     = 6'd48;
  localparam logic [3:0]         CODE_MASK_3  = 4'he;
  localparam logic [3:0]         CODE_MASK_4  = 4'hf;
  localparam int                 GAIN_SHIFT   = 7;
  localparam logic [23:0]        GAIN_ROUND   = 24'd127;

  // Step size table, floor(16 * 1.1^n)
  function automatic logic [10:0] step_size(input logic [5:0] idx);
    logic [10:0] s;
    case (idx)
      6'd0:  s = 11'd16;   6'd1:  s = 11'd17;   6'd2:  s = 11'd19;   6'd3:  s = 11'd21;
      6'd4:  s = 11'd23;   6'd5:  s = 11'd25;   6'd6:  s = 11'd28;   6'd7:  s = 11'd31;
      6'd8:  s = 11'd34;   6'd9:  s = 11'd37;   6'd10: s = 11'd41;   6'd11: s = 11'd45;
      6'd12: s = 11'd50;   6'd13: s = 11'd55;   6'd14: s = 11'd60;   6'd15: s = 11'd66;
      6'd16: s = 11'd73;   6'd17: s = 11'd80;   6'd18: s = 11'd88;   6'd19: s = 11'd97;
      6'd20: s = 11'd107;  6'd21: s = 11'd118;  6'd22: s = 11'd130;  6'd23: s = 11'd143;
      6'd24: s = 11'd157;  6'd25: s = 11'd173;  6'd26: s = 11'd190;  6'd27: s = 11'd209;
      6'd28: s = 11'd230;  6'd29: s = 11'd253;  6'd30: s = 11'd279;  6'd31: s = 11'd307;
      6'd32: s = 11'd337;  6'd33: s = 11'd371;  6'd34: s = 11'd408;  6'd35: s = 11'd449;
      6'd36: s = 11'd494;  6'd37: s = 11'd544;  6'd38: s = 11'd598;  6'd39: s = 11'd658;
      6'd40: s = 11'd724;  6'd41: s = 11'd796;  6'd42: s = 11'd876;  6'd43: s = 11'd963;
      6'd44: s = 11'd1060; 6'd45: s = 11'd1166; 6'd46: s = 11'd1282; 6'd47: s = 11'd1411;
      default: s = 11'd1552;
    endcase
    return s;
  endfunction

  // Step index adjustment by code magnitude
  function automatic logic signed [4:0] step_move(input logic [2:0] mag);
    logic signed [4:0] m;
    case (mag)
      3'd4:    m = 5'sd8;
      3'd5:    m = 5'sd4;
      3'd6:    m = 5'sd2;
      3'd7:    m = 5'sd1;
      default: m = -5'sd1;
    endcase
    return m;
  endfunction

endpackage

### design/avd_state_mem.sv
module avd_state_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output avd_pkg::voice_state_t rd_data,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  avd_pkg::voice_state_t wr_data
);

  avd_pkg::voice_state_t mem [DEPTH];
  logic [DEPTH-1:0]      written;
  avd_pkg::voice_state_t rd_raw;
  logic                  rd_vld;
  avd_pkg::voice_state_t reset_state;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Entry valid flags, cleared together on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  // Registered read, write-first when both ports hit one entry
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_raw <= wr_data;
        rd_vld <= 1'b1;
      end else begin
        rd_raw <= mem[rd_addr];
        rd_vld <= written[rd_addr];
      end
    end
  end

  // Never-written entries read as the reset state
  always_comb begin
    reset_state.signal = avd_pkg::SIGNAL_RESET;
    reset_state.step   = '0;
    reset_state.mode   = 1'b0;
    rd_data = rd_vld ? rd_raw : reset_state;
  end

endmodule

### design/avd_core.sv
module avd_core (
  input  avd_pkg::voice_state_t state,
  input  logic                  start,
  input  logic                  in_range,
  input  logic [3:0]            code,
  input  logic                  mode,
  output avd_pkg::voice_state_t state_next,
  output logic signed [11:0]    sample
);

  logic [3:0]         code_m;
  logic [10:0]        s;
  logic [11:0]        diff;
  logic signed [13:0] sum;
  logic signed [11:0] sig_clamped;
  logic signed [7:0]  step_sum;
  logic [5:0]         step_clamped;

  // Mask code, build difference from step size
  always_comb begin
    code_m = code & (state.mode ? avd_pkg::CODE_MASK_3 : avd_pkg::CODE_MASK_4);
    s      = avd_pkg::step_size(state.step);
    diff   = 12'(s >> 3)
           + (code_m[2] ? 12'(s) : 12'd0)
           + (code_m[1] ? 12'(s >> 1) : 12'd0)
           + (code_m[0] ? 12'(s >> 2) : 12'd0);
  end

  // Signal update with saturation
  always_comb begin
    if (code_m[3]) begin
      sum = 14'(state.signal) - $signed({2'b00, diff});
    end else begin
      sum = 14'(state.signal) + $signed({2'b00, diff});
    end
    if (sum > avd_pkg::SIGNAL_MAX) begin
      sig_clamped = 12'(avd_pkg::SIGNAL_MAX);
    end else if (sum < avd_pkg::SIGNAL_MIN) begin
      sig_clamped = 12'(avd_pkg::SIGNAL_MIN);
    end else begin
      sig_clamped = sum[11:0];
    end
  end

  // Step index update, kept within the table
  always_comb begin
    step_sum = $signed({2'b00, state.step}) + 8'(avd_pkg::step_move(code_m[2:0]));
    if (step_sum < 8'sd0) begin
      step_clamped = '0;
    end else if (step_sum > $signed({2'b00, avd_pkg::STEP_MAX})) begin
      step_clamped = avd_pkg::STEP_MAX;
    end else begin
      step_clamped = step_sum[5:0];
    end
  end

  // Start resets the voice, decode commits the new signal and step
  always_comb begin
    if (start) begin
      state_next.signal = avd_pkg::SIGNAL_RESET;
      state_next.step   = '0;
      state_next.mode   = mode;
    end else begin
      state_next.signal = sig_clamped;
      state_next.step   = step_clamped;
      state_next.mode   = state.mode;
    end
    sample = in_range ? state_next.signal : '0;
  end

endmodule

### design/avd_gain.sv
module avd_gain (
  input  logic signed [11:0] sample,
  input  logic [10:0]        gain,
  output logic signed [15:0] scaled
);

  logic signed [23:0] prod;
  logic signed [23:0] biased;
  logic signed [23:0] shifted;

  // Product over 128, truncated toward zero
  always_comb begin
    prod    = 24'(sample) * $signed({13'd0, gain});
    biased  = prod[23] ? (prod + $signed(avd_pkg::GAIN_ROUND)) : prod;
    shifted = biased >>> avd_pkg::GAIN_SHIFT;
    scaled  = shifted[15:0];
  end

endmodule

### design/multichannel_adpcm_voice_decoder.sv
// Channel  Side    tdata (low bit up)                                 tuser
// s_axis   in      voice[3:0] code[7:4] three_bit_mode[8]             command
//                  gain_left[19:9] gain_right[30:20], zero pad to 32
// m_axis   out     sample[11:0] left_out[27:12] right_out[43:28],     -
//                  zero pad to 48
//
// One word accepted per cycle unless m_axis stalls; each result passes the stage 1, stage 2 and output registers.
// Stages: state memory read, decode and state write-back, gain multiply.
// A word for the voice just decoded is served by the write-first memory port.
// rst is synchronous; it empties the pipe and marks every voice as reset.
// A stalled m_axis holds the whole pipe and drops s_axis_tready.
module multichannel_adpcm_voice_decoder #(
  parameter int VOICES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // voice, code, three_bit_mode, gain_left, gain_right
  input  logic        s_axis_tuser,   // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // sample, left_out, right_out
);

  localparam int AW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int VW = (AW > 4) ? AW : 4;

  logic                  en;
  logic [3:0]            in_voice;
  logic [VW-1:0]         voice_ext;
  logic                  in_range;

  logic                  s1_valid;
  logic                  s1_start;
  logic                  s1_in_range;
  logic [AW-1:0]         s1_addr;
  logic [3:0]            s1_code;
  logic                  s1_mode;
  logic [10:0]           s1_gl;
  logic [10:0]           s1_gr;

  logic                  s2_valid;
  logic signed [11:0]    s2_sample;
  logic [10:0]           s2_gl;
  logic [10:0]           s2_gr;

  logic                  out_valid;
  logic signed [11:0]    out_sample;
  logic signed [15:0]    out_left;
  logic signed [15:0]    out_right;

  avd_pkg::voice_state_t rd_state;
  avd_pkg::voice_state_t state_next;
  logic                  wr_en;
  logic signed [11:0]    core_sample;
  logic signed [15:0]    left_next;
  logic signed [15:0]    right_next;

  // Pipe advances whenever the output register is free or draining
  assign en            = !out_valid || m_axis_tready;
  assign s_axis_tready = en && !rst;

  assign in_voice  = s_axis_tdata[3:0];
  assign voice_ext = VW'(in_voice);
  assign in_range  = ({28'd0, in_voice} < 32'(VOICES));

  // Per-voice state
  assign wr_en = en && s1_valid && s1_in_range;

  avd_state_mem #(
    .DEPTH (VOICES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (en && s_axis_tvalid),
    .rd_addr (voice_ext[AW-1:0]),
    .rd_data (rd_state),
    .wr_en   (wr_en),
    .wr_addr (s1_addr),
    .wr_data (state_next)
  );

  // Stage 1: word register alongside the memory read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= s_axis_tvalid;
    end
    if (en) begin
      s1_start    <= (avd_pkg::command_t'(s_axis_tuser) == avd_pkg::CMD_START);
      s1_in_range <= in_range;
      s1_addr     <= voice_ext[AW-1:0];
      s1_code     <= s_axis_tdata[7:4];
      s1_mode     <= s_axis_tdata[8];
      s1_gl       <= s_axis_tdata[19:9];
      s1_gr       <= s_axis_tdata[30:20];
    end
  end

  avd_core u_core (
    .state      (rd_state),
    .start      (s1_start),
    .in_range   (s1_in_range),
    .code       (s1_code),
    .mode       (s1_mode),
    .state_next (state_next),
    .sample     (core_sample)
  );

  // Stage 2: decoded sample
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
    if (en) begin
      s2_sample <= core_sample;
      s2_gl     <= s1_gl;
      s2_gr     <= s1_gr;
    end
  end

  avd_gain u_gain_left (
    .sample (s2_sample),
    .gain   (s2_gl),
    .scaled (left_next)
  );

  avd_gain u_gain_right (
    .sample (s2_sample),
    .gain   (s2_gr),
    .scaled (right_next)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s2_valid;
    end
    if (en) begin
      out_sample <= s2_sample;
      out_left   <= left_next;
      out_right  <= right_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'd0, out_right, out_left, out_sample};

`ifndef NO_ASSERTIONS
  a_reset_empties: assert property (@(posedge clk)
    rst |=> (!s1_valid && !s2_valid && !m_axis_tvalid))
    else $error("pipe not empty after reset");

  a_start_sample: assert property (@(posedge clk) disable iff (rst)
    (en && s1_valid && s1_start && s1_in_range) |=> (s2_sample == avd_pkg::SIGNAL_RESET))
    else $error("start word did not give the reset signal");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    (en && s1_valid && !s1_in_range) |=> (s2_sample == 12'sd0))
    else $error("out-of-range voice gave a non-zero sample");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state_next.step <= avd_pkg::STEP_MAX))
    else $error("step index written beyond table");

  a_sample_follows: assert property (@(posedge clk) disable iff (rst)
    (en && s2_valid) |=> (m_axis_tdata[11:0] == $past(s2_sample)))
    else $error("output sample does not match decoded sample");
`endif

endmodule
